// ----- hw/rtl/glyph_column_rasterizer_macros.svh -----
// Assertion macros shared by the glyph column rasterizer RTL.
`ifndef GLYPH_COLUMN_RASTERIZER_MACROS_SVH
`define GLYPH_COLUMN_RASTERIZER_MACROS_SVH

// Check a property while out of reset.
`define GCR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property at every edge, reset included.
`define GCR_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- hw/rtl/gcr_pkg.sv -----
// Shared types and constants of the glyph column rasterizer.
package gcr_pkg;

  localparam int TABLES_DEF   = 8;
  localparam int CHARS_DEF    = 128;
  localparam int STRIDE_DEF   = 64;
  localparam int MAX_ROWS_DEF = 32;

  localparam int GLYPH_AW    = 16;
  localparam int GLYPH_DEPTH = 1 << GLYPH_AW;

  localparam int ACTION_W    = 3;
  localparam int IN_DATA_W   = 40;
  localparam int OUT_DATA_W  = 48;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 16;

  localparam logic [ACTION_W-1:0] ACT_WRITE = 3'd0;
  localparam logic [ACTION_W-1:0] ACT_FIRST = 3'd1;
  localparam logic [ACTION_W-1:0] ACT_CHAR  = 3'd2;
  localparam logic [ACTION_W-1:0] ACT_PULL  = 3'd3;
  localparam logic [ACTION_W-1:0] ACT_START = 3'd4;

  localparam logic [CFG_INDEX_W-1:0] REG_INK    = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_PAPER  = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_GAP    = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_ROWS   = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_CBYTES = 3'd4;

  localparam logic KIND_ADVANCE = 1'b0;
  localparam logic KIND_PIXEL   = 1'b1;

  localparam logic [7:0]  SELECT_CODES     = 8'd9;
  localparam logic [2:0]  MAX_COLUMN_BYTES = 3'd4;
  localparam logic [15:0] INK_RESET        = 16'hFFFF;
  localparam logic [15:0] PAPER_RESET      = 16'h0000;
  localparam logic [4:0]  GAP_RESET        = 5'd0;
  localparam logic [5:0]  ROWS_RESET       = 6'd8;
  localparam logic [2:0]  CBYTES_RESET     = 3'd1;

  localparam int OUT_DEPTH = 4;
  localparam int OUT_CNT_W = $clog2(OUT_DEPTH + 1);

  typedef struct packed {
    logic        kind;
    logic [15:0] pixel_color;
    logic        last_of_glyph;
    logic [8:0]  char_advance;
    logic [15:0] text_width;
  } gcr_result_t;

endpackage

// ----- hw/rtl/glyph_column_rasterizer.sv -----
// Top level of the glyph column rasterizer: text to column-major RGB565 pixels.
// Each accepted beat makes one glyph memory access; a result passes the registered memory
// read and the output queue before it shows on out, and one beat per cycle is sustained
// while the queue has room. The single glyph memory port and the 4-entry output queue set
// that rate; in_tready drops only while the queue cannot take the results in flight.
// Synchronous rst_n clears control state and loads register defaults; glyph memory keeps
// its contents and has no clearing pass.
module glyph_column_rasterizer #(
  parameter int TABLES          = gcr_pkg::TABLES_DEF,
  parameter int CHARS_PER_TABLE = gcr_pkg::CHARS_DEF,
  parameter int GLYPH_STRIDE    = gcr_pkg::STRIDE_DEF,
  parameter int MAX_ROWS        = gcr_pkg::MAX_ROWS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // glyph_address, glyph_byte, table_number, char_code
  input  logic [gcr_pkg::IN_DATA_W-1:0]   in_tdata,
  // action
  input  logic [gcr_pkg::ACTION_W-1:0]    in_tuser,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // pixel_color, char_advance, text_width
  output logic [gcr_pkg::OUT_DATA_W-1:0]  out_tdata,
  output logic                           out_tlast,
  // kind
  output logic                           out_tuser,
  input  logic                           cfg_we,
  input  logic [gcr_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [gcr_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import gcr_pkg::*;

  localparam int TW = $clog2(TABLES);
  localparam int IW = $clog2(CHARS_PER_TABLE);

  typedef struct packed {
    logic       ok;
    logic [8:0] col;
    logic [1:0] byt;
    logic [2:0] bt;
  } settle_t;

  function automatic settle_t settle_pos(input logic [8:0] col, input logic [1:0] byt,
                                         input logic [3:0] bt, input logic [7:0] gw,
                                         input logic [4:0] gap, input logic [5:0] rows,
                                         input logic [2:0] cb);
    logic [8:0] cols;
    logic [2:0] nb;
    logic [2:0] eg;
    logic [2:0] eh;
    logic [5:0] lo;
    logic [5:0] rem;
    logic [3:0] nbits;
    logic [8:0] c1;
    settle_t    res;
    cols  = {1'b0, gw} + {4'b0, gap};
    nb    = 3'((rows + 6'd7) >> 3);
    eg    = (cb < nb) ? cb : nb;
    eh    = (col < {1'b0, gw}) ? eg : nb;
    lo    = {1'b0, byt, 3'b000};
    rem   = rows - lo;
    nbits = (rows <= lo) ? 4'd0 : ((rem >= 6'd8) ? 4'd8 : rem[3:0]);
    c1    = col + 9'd1;
    if ((c1 < {1'b0, gw}) && (eg == 3'd0)) begin
      c1 = {1'b0, gw};
    end
    res = '0;
    if (col >= cols) begin
      res.ok = 1'b0;
    end else if (({1'b0, byt} < eh) && (bt < nbits)) begin
      res.ok  = 1'b1;
      res.col = col;
      res.byt = byt;
      res.bt  = bt[2:0];
    end else if (({1'b0, byt} + 3'd1) < eh) begin
      res.ok  = 1'b1;
      res.col = col;
      res.byt = byt + 2'd1;
    end else if ((c1 < cols) && (nb != 3'd0)) begin
      res.ok  = 1'b1;
      res.col = c1;
    end
    return res;
  endfunction

  logic [15:0] ink_r;
  logic [15:0] paper_r;
  logic [4:0]  gap_r;
  logic [5:0]  rows_r;
  logic [2:0]  cbytes_r;
  logic [5:0]  rows_eff;
  logic [2:0]  cb_sat;

  logic [7:0]    first_r [TABLES];
  logic [TW-1:0] chosen_r;
  logic [15:0]   base_r;
  logic [7:0]    gw_r;
  logic [8:0]    col_r;
  logic [1:0]    byt_r;
  logic [2:0]    bt_r;
  logic          pend_r;
  logic [15:0]   width_sum_r;

  logic          s1_char_r;
  logic          s1_pix_r;
  logic          s1_gcol_r;
  logic [2:0]    s1_bit_r;
  logic          s1_last_r;
  logic          s1_res;

  logic [ACTION_W-1:0] action;
  logic [15:0]   in_addr;
  logic [7:0]    in_byte;
  logic [2:0]    in_tnum;
  logic [7:0]    in_code;
  logic          in_acc;
  logic          is_write;
  logic          is_first;
  logic          is_select;
  logic          is_char;
  logic          is_pull;
  logic          is_start;

  logic [IW-1:0] mod_lut [256];
  logic [15:0]   tbase [TABLES];
  logic [TW-1:0] sel_t;
  logic [7:0]    fc;
  logic [8:0]    diff;
  logic [8:0]    neg;
  logic [7:0]    mag;
  logic [IW-1:0] rem;
  logic [8:0]    idx_neg;
  logic [IW-1:0] idx;
  logic [23:0]   offset;
  logic [15:0]   char_base;

  logic [7:0]    gw_cur;
  logic [8:0]    base_col;
  logic [1:0]    base_byt;
  logic [2:0]    base_bt;
  logic          base_pend;
  settle_t       cur;
  settle_t       nxt;
  logic          cur_ok;
  logic          pix_emit;
  logic [10:0]   colmul;
  logic [15:0]   pix_addr;

  logic          ram_we;
  logic [15:0]   ram_addr;
  logic [7:0]    ram_rdata;

  logic [8:0]    adv;
  logic [15:0]   total;
  logic          pix_bit;
  gcr_result_t   res;
  gcr_result_t   head;
  logic          fifo_valid;
  logic [OUT_CNT_W-1:0] fifo_cnt;

  assign action  = in_tuser;
  assign in_addr = in_tdata[15:0];
  assign in_byte = in_tdata[23:16];
  assign in_tnum = in_tdata[26:24];
  assign in_code = in_tdata[34:27];

  assign in_tready = ({1'b0, fifo_cnt} + {{OUT_CNT_W{1'b0}}, s1_res}) < (OUT_CNT_W + 1)'(OUT_DEPTH);
  assign in_acc    = in_tvalid && in_tready;
  assign is_write  = in_acc && (action == ACT_WRITE);
  assign is_first  = in_acc && (action == ACT_FIRST);
  assign is_select = in_acc && (action == ACT_CHAR) && (in_code != 8'd0) &&
                     (in_code < SELECT_CODES);
  assign is_char   = in_acc && (action == ACT_CHAR) && (in_code >= SELECT_CODES);
  assign is_pull   = in_acc && (action == ACT_PULL);
  assign is_start  = in_acc && (action == ACT_START);

  assign rows_eff = (int'(rows_r) > MAX_ROWS) ? 6'(MAX_ROWS) : rows_r;
  assign cb_sat   = (cbytes_r > MAX_COLUMN_BYTES) ? MAX_COLUMN_BYTES : cbytes_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ink_r    <= INK_RESET;
      paper_r  <= PAPER_RESET;
      gap_r    <= GAP_RESET;
      rows_r   <= ROWS_RESET;
      cbytes_r <= CBYTES_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_INK:    ink_r    <= cfg_wdata;
        REG_PAPER:  paper_r  <= cfg_wdata;
        REG_GAP:    gap_r    <= cfg_wdata[4:0];
        REG_ROWS:   rows_r   <= cfg_wdata[5:0];
        REG_CBYTES: cbytes_r <= cfg_wdata[2:0];
        default: begin
        end
      endcase
    end
  end

  for (genvar i = 0; i < 256; i++) begin : g_mod
    assign mod_lut[i] = IW'(i % CHARS_PER_TABLE);
  end

  for (genvar t = 0; t < TABLES; t++) begin : g_tbase
    assign tbase[t] = 16'((t * CHARS_PER_TABLE * GLYPH_STRIDE) % GLYPH_DEPTH);
  end

  assign sel_t     = (chosen_r > TW'(1)) ? chosen_r :
                     ((in_code >= first_r[1]) ? TW'(1) : TW'(0));
  assign fc        = first_r[sel_t];
  assign diff      = {1'b0, in_code} - {1'b0, fc};
  assign neg       = 9'd0 - diff;
  assign mag       = diff[8] ? neg[7:0] : diff[7:0];
  assign rem       = mod_lut[mag];
  assign idx_neg   = 9'(CHARS_PER_TABLE) - 9'(rem);
  assign idx       = (diff[8] && (rem != '0)) ? idx_neg[IW-1:0] : rem;
  assign offset    = 24'(idx) * 24'(GLYPH_STRIDE);
  assign char_base = tbase[sel_t] + offset[15:0];

  assign gw_cur    = s1_char_r ? ram_rdata : gw_r;
  assign base_col  = s1_char_r ? 9'd0 : col_r;
  assign base_byt  = s1_char_r ? 2'd0 : byt_r;
  assign base_bt   = s1_char_r ? 3'd0 : bt_r;
  assign base_pend = s1_char_r || pend_r;

  assign cur      = settle_pos(base_col, base_byt, {1'b0, base_bt}, gw_cur, gap_r, rows_eff,
                               cb_sat);
  assign cur_ok   = base_pend && cur.ok;
  assign nxt      = settle_pos(cur.col, cur.byt, {1'b0, cur.bt} + 4'd1, gw_cur, gap_r,
                               rows_eff, cb_sat);
  assign pix_emit = is_pull && cur_ok;

  always_comb begin
    case (cb_sat)
      3'd1:    colmul = {2'b0, cur.col};
      3'd2:    colmul = {1'b0, cur.col, 1'b0};
      3'd3:    colmul = {2'b0, cur.col} + {1'b0, cur.col, 1'b0};
      3'd4:    colmul = {cur.col, 2'b0};
      default: colmul = 11'd0;
    endcase
  end

  assign pix_addr = base_r + 16'd1 + 16'(colmul) + 16'(cur.byt);

  assign ram_we   = is_write;
  assign ram_addr = is_write ? in_addr : (is_char ? char_base : pix_addr);

  gcr_glyph_ram u_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (in_byte),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < TABLES; i++) begin
        first_r[i] <= 8'd0;
      end
      chosen_r <= '0;
      base_r   <= 16'd0;
    end else begin
      if (is_first && (int'(in_tnum) < TABLES)) begin
        first_r[in_tnum[TW-1:0]] <= in_byte;
      end
      if (is_start) begin
        chosen_r <= '0;
      end else if (is_select && ((int'(in_code) - 1) < TABLES)) begin
        chosen_r <= TW'(in_code - 8'd1);
      end
      if (is_char) begin
        base_r <= char_base;
      end
    end
  end

  assign adv   = {1'b0, ram_rdata} + {4'b0, gap_r};
  assign total = width_sum_r + 16'(adv);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gw_r        <= 8'd0;
      col_r       <= 9'd0;
      byt_r       <= 2'd0;
      bt_r        <= 3'd0;
      pend_r      <= 1'b0;
      width_sum_r <= 16'd0;
    end else begin
      if (s1_char_r) begin
        gw_r <= ram_rdata;
      end
      if (is_start) begin
        col_r  <= 9'd0;
        byt_r  <= 2'd0;
        bt_r   <= 3'd0;
        pend_r <= 1'b0;
      end else if (is_pull) begin
        if (cur_ok) begin
          col_r  <= nxt.col;
          byt_r  <= nxt.byt;
          bt_r   <= nxt.bt;
          pend_r <= nxt.ok;
        end else begin
          pend_r <= 1'b0;
        end
      end else if (s1_char_r) begin
        col_r  <= cur.col;
        byt_r  <= cur.byt;
        bt_r   <= cur.bt;
        pend_r <= cur.ok;
      end
      if (is_start) begin
        width_sum_r <= 16'd0;
      end else if (s1_char_r) begin
        width_sum_r <= total;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_char_r <= 1'b0;
      s1_pix_r  <= 1'b0;
    end else begin
      s1_char_r <= is_char;
      s1_pix_r  <= pix_emit;
    end
  end

  always_ff @(posedge clk) begin
    s1_gcol_r <= (cur.col < {1'b0, gw_cur});
    s1_bit_r  <= cur.bt;
    s1_last_r <= !nxt.ok;
  end

  assign s1_res  = s1_char_r || s1_pix_r;
  assign pix_bit = ram_rdata[s1_bit_r];

  always_comb begin
    res = '0;
    if (s1_char_r) begin
      res.kind         = KIND_ADVANCE;
      res.char_advance = adv;
      res.text_width   = total;
    end else begin
      res.kind          = KIND_PIXEL;
      res.pixel_color   = (s1_gcol_r && pix_bit) ? ink_r : paper_r;
      res.last_of_glyph = s1_last_r;
    end
  end

  gcr_out_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (s1_res),
    .push_data (res),
    .pop       (out_tready),
    .head      (head),
    .valid     (fifo_valid),
    .count     (fifo_cnt)
  );

  assign out_tvalid = fifo_valid;
  assign out_tdata  = {7'b0, head.text_width, head.char_advance, head.pixel_color};
  assign out_tlast  = head.last_of_glyph;
  assign out_tuser  = head.kind;

`include "glyph_column_rasterizer_macros.svh"

  `GCR_ASSERT(a_queue_room, s1_res |-> (fifo_cnt < OUT_CNT_W'(OUT_DEPTH)), "output queue overrun")
  `GCR_ASSERT(a_start_clears, is_start |=> (!pend_r && (width_sum_r == 16'd0)), "start text not applied")
  `GCR_ASSERT(a_write_silent, is_write |=> !s1_res, "glyph write produced a result")
  `GCR_ASSERT(a_pull_idle, (is_pull && !pend_r && !s1_char_r) |=> !s1_pix_r, "pixel with no cell")
  `GCR_ASSERT_RST(a_reset_clear, !rst_n |=> (!s1_res && !pend_r), "reset left work in flight")

endmodule

// ----- hw/rtl/gcr_glyph_ram.sv -----
// Single-port glyph byte memory with registered read data.
module gcr_glyph_ram (
  input  logic                       clk,
  input  logic                       we,
  input  logic [gcr_pkg::GLYPH_AW-1:0] addr,
  input  logic [7:0]                 wdata,
  output logic [7:0]                 rdata
);
  import gcr_pkg::*;

  logic [7:0] mem [GLYPH_DEPTH];
  logic [7:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end else begin
      rdata_r <= mem[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- hw/rtl/gcr_out_fifo.sv -----
// Output result queue between the render pipeline and the out channel.
module gcr_out_fifo (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         push,
  input  gcr_pkg::gcr_result_t         push_data,
  input  logic                         pop,
  output gcr_pkg::gcr_result_t         head,
  output logic                         valid,
  output logic [gcr_pkg::OUT_CNT_W-1:0] count
);
  import gcr_pkg::*;

  localparam int PTR_W = $clog2(OUT_DEPTH);

  gcr_result_t            mem [OUT_DEPTH];
  logic [PTR_W-1:0]       wr_ptr_r;
  logic [PTR_W-1:0]       rd_ptr_r;
  logic [OUT_CNT_W-1:0]   cnt_r;
  logic [OUT_CNT_W-1:0]   cnt_nxt;
  logic                   do_pop;

  assign do_pop = pop && (cnt_r != '0);

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !do_pop) begin
      cnt_nxt = cnt_r + OUT_CNT_W'(1);
    end else if (!push && do_pop) begin
      cnt_nxt = cnt_r - OUT_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + PTR_W'(1);
      end
      cnt_r <= cnt_nxt;
    end
  end

  assign head  = mem[rd_ptr_r];
  assign valid = (cnt_r != '0);
  assign count = cnt_r;

endmodule

// ----- tb/testbench.sv -----
// Stimulus, checking and pixel prediction for the glyph column rasterizer.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import gcr_pkg::*;

  localparam int SETTLE_CYCLES = 12;
  localparam int CODE_POOL     = 16;

  typedef enum logic [1:0] {RX_FREE, RX_COIN, RX_SPARSE, RX_BLOCKED} rx_mode_e;

  class raster_scoreboard;
    logic [7:0]  store [GLYPH_DEPTH];
    bit          written [GLYPH_DEPTH];
    logic [7:0]  first_char [TABLES_DEF];
    logic [2:0]  table_sel;
    logic [15:0] base;
    logic [7:0]  gwidth;
    int unsigned col;
    int unsigned byte_idx;
    int unsigned bit_idx;
    bit          pending;
    logic [15:0] width_sum;
    logic [15:0] ink;
    logic [15:0] paper;
    logic [4:0]  gap;
    logic [5:0]  rows;
    logic [2:0]  cbytes;
    gcr_result_t awaited [$];
    int          failures;

    function new();
      foreach (first_char[i]) first_char[i] = 8'd0;
      table_sel = 3'd0;
      base      = 16'd0;
      gwidth    = 8'd0;
      col       = 0;
      byte_idx  = 0;
      bit_idx   = 0;
      pending   = 1'b0;
      width_sum = 16'd0;
      ink       = INK_RESET;
      paper     = PAPER_RESET;
      gap       = GAP_RESET;
      rows      = ROWS_RESET;
      cbytes    = CBYTES_RESET;
      failures  = 0;
    endfunction

    function int unsigned bits_in(int unsigned b);
      int unsigned r;
      r = (rows > MAX_ROWS_DEF) ? MAX_ROWS_DEF : rows;
      if (r <= b * 8) return 0;
      return (r - b * 8 >= 8) ? 8 : r - b * 8;
    endfunction

    // advance to the next position that holds a pixel; 0 when the cell is done
    function bit advance_cursor();
      int unsigned cols;
      int unsigned cb;
      int unsigned nbytes;
      cols = gwidth + gap;
      cb = (cbytes > MAX_COLUMN_BYTES) ? MAX_COLUMN_BYTES : cbytes;
      while (col < cols) begin
        nbytes = (col < gwidth) ? cb : MAX_COLUMN_BYTES;
        if (byte_idx >= nbytes) begin
          col++;
          byte_idx = 0;
          bit_idx = 0;
        end else if (bit_idx >= bits_in(byte_idx)) begin
          byte_idx++;
          bit_idx = 0;
        end else begin
          return 1'b1;
        end
      end
      return 1'b0;
    endfunction

    function logic [15:0] base_for(logic [7:0] code);
      int unsigned t;
      int d;
      t = (table_sel > 1) ? table_sel : ((code >= first_char[1]) ? 1 : 0);
      d = (int'(code) - int'(first_char[t])) % CHARS_DEF;
      if (d < 0) d += CHARS_DEF;
      return 16'(t * CHARS_DEF * STRIDE_DEF + d * STRIDE_DEF);
    endfunction

    function void set_config(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        REG_INK:    ink = val;
        REG_PAPER:  paper = val;
        REG_GAP:    gap = val[4:0];
        REG_ROWS:   rows = val[5:0];
        REG_CBYTES: cbytes = val[2:0];
        default: ;
      endcase
    endfunction

    function void note_beat(logic [ACTION_W-1:0] act, logic [15:0] addr, logic [7:0] gbyte,
                            logic [2:0] tnum, logic [7:0] code);
      gcr_result_t res;
      int unsigned cb;
      logic [15:0] a;
      logic [8:0]  adv;
      logic [15:0] color;
      res = '0;
      case (act)
        ACT_WRITE: begin
          store[addr] = gbyte;
          written[addr] = 1'b1;
        end
        ACT_FIRST: if (tnum < TABLES_DEF) first_char[tnum] = gbyte;
        ACT_CHAR: begin
          if (code >= SELECT_CODES) begin
            base = base_for(code);
            gwidth = store[base];
            adv = gwidth + gap;
            width_sum = width_sum + adv;
            col = 0;
            byte_idx = 0;
            bit_idx = 0;
            pending = advance_cursor();
            res.kind = KIND_ADVANCE;
            res.char_advance = adv;
            res.text_width = width_sum;
            awaited.push_back(res);
          end else if (code != 8'd0 && code - 8'd1 < TABLES_DEF) begin
            table_sel = 3'(code - 8'd1);
          end
        end
        ACT_PULL: begin
          if (pending) begin
            if (!advance_cursor()) begin
              pending = 1'b0;
            end else begin
              if (col < gwidth) begin
                cb = (cbytes > MAX_COLUMN_BYTES) ? MAX_COLUMN_BYTES : cbytes;
                a = base + 16'(1 + col * cb + byte_idx);
                color = store[a][bit_idx % 8] ? ink : paper;
              end else begin
                color = paper;
              end
              bit_idx++;
              pending = advance_cursor();
              res.kind = KIND_PIXEL;
              res.pixel_color = color;
              res.last_of_glyph = !pending;
              awaited.push_back(res);
            end
          end
        end
        ACT_START: begin
          width_sum = 16'd0;
          table_sel = 3'd0;
          pending = 1'b0;
          col = 0;
          byte_idx = 0;
          bit_idx = 0;
        end
        default: ;
      endcase
    endfunction

    function void check_output(logic kind, logic [OUT_DATA_W-1:0] data, logic last);
      gcr_result_t got;
      gcr_result_t want;
      got.kind = kind;
      got.pixel_color = data[15:0];
      got.last_of_glyph = last;
      got.char_advance = data[24:16];
      got.text_width = data[40:25];
      if (awaited.size() == 0) begin
        failures++;
        if (failures <= 10)
          $display("unexpected beat: kind=%0b color=%h last=%0b advance=%0d width=%0d",
                   got.kind, got.pixel_color, got.last_of_glyph, got.char_advance,
                   got.text_width);
        return;
      end
      want = awaited.pop_front();
      if (got !== want) begin
        failures++;
        if (failures <= 10) begin
          $display("mismatch: expected kind=%0b color=%h last=%0b advance=%0d width=%0d",
                   want.kind, want.pixel_color, want.last_of_glyph, want.char_advance,
                   want.text_width);
          $display("          actual   kind=%0b color=%h last=%0b advance=%0d width=%0d",
                   got.kind, got.pixel_color, got.last_of_glyph, got.char_advance,
                   got.text_width);
        end
      end
    endfunction
  endclass

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_DATA_W-1:0]   in_tdata = '0;
  logic [ACTION_W-1:0]    in_tuser = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_DATA_W-1:0]  out_tdata;
  logic                   out_tlast;
  logic                   out_tuser;
  logic                   cfg_we = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_wdata = '0;

  raster_scoreboard sb;
  int          burst_left = 0;
  bit          steady = 1'b0;
  rx_mode_e    rx_mode = RX_FREE;
  int          rx_left = 0;
  int unsigned rx_tick = 0;
  logic [7:0]  code_pool [CODE_POOL];

  glyph_column_rasterizer DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast),
    .out_tuser (out_tuser),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_output(out_tuser, out_tdata, out_tlast);
    if (rx_left == 0) begin
      rx_mode = rx_mode_e'($urandom_range(0, 3));
      rx_left = $urandom_range(20, 120);
    end
    rx_left--;
    rx_tick++;
    case (rx_mode)
      RX_FREE:   out_tready <= 1'b1;
      RX_COIN:   out_tready <= 1'($urandom_range(0, 1));
      RX_SPARSE: out_tready <= (rx_tick % 4 == 0);
      default:   out_tready <= (rx_tick % 24 >= 16);
    endcase
  end

  task automatic send_beat(input logic [ACTION_W-1:0] act, input logic [15:0] addr,
                           input logic [7:0] gbyte, input logic [2:0] tnum,
                           input logic [7:0] code);
    if (burst_left == 0) begin
      if (!steady) begin
        in_tvalid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tuser  <= act;
    in_tdata  <= {5'd0, code, tnum, gbyte, addr};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_beat(act, addr, gbyte, tnum, code);
  endtask

  // hold off input until every predicted beat has arrived, then let the pipe settle
  task automatic drain_outputs();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.awaited.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    sb.set_config(idx, val);
  endtask

  task automatic write_settings(input logic [15:0] ink, input logic [15:0] paper,
                                input logic [4:0] gap, input logic [5:0] rows,
                                input logic [2:0] cb);
    drain_outputs();
    cfg_write(REG_INK, ink);
    cfg_write(REG_PAPER, paper);
    cfg_write(REG_GAP, 16'(gap));
    cfg_write(REG_ROWS, 16'(rows));
    cfg_write(REG_CBYTES, 16'(cb));
    cfg_we <= 1'b0;
  endtask

  function automatic logic [7:0] pick_width();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 3) return 8'hFF;
    if (r < 70) return 8'($urandom_range(0, 5));
    return 8'($urandom_range(6, 12));
  endfunction

  function automatic logic [7:0] pick_code();
    if ($urandom_range(0, 9) < 7) return code_pool[$urandom_range(0, CODE_POOL - 1)];
    return 8'($urandom_range(SELECT_CODES, 255));
  endfunction

  // fill the width byte and every column byte any column setting can reach
  task automatic prepare_glyph(input logic [7:0] code, input logic [7:0] width);
    logic [15:0] b;
    int unsigned w;
    b = sb.base_for(code);
    if (!sb.written[b]) send_beat(ACT_WRITE, b, width, $urandom, $urandom);
    w = sb.store[b];
    for (int unsigned i = 1; i <= w * MAX_COLUMN_BYTES; i++)
      if (!sb.written[16'(b + i)]) send_beat(ACT_WRITE, 16'(b + i), $urandom, $urandom, $urandom);
  endtask

  task automatic send_char(input logic [7:0] code);
    if (code >= SELECT_CODES) prepare_glyph(code, pick_width());
    send_beat(ACT_CHAR, $urandom, $urandom, $urandom, code);
  endtask

  task automatic pull_cell(input int limit, output int n);
    n = 0;
    while (sb.pending && n < limit) begin
      send_beat(ACT_PULL, $urandom, $urandom, $urandom, $urandom);
      n++;
    end
  endtask

  task automatic random_phase(input int quota);
    int done;
    int n;
    int r;
    done = 0;
    steady = ($urandom_range(0, 3) == 0);
    pull_cell($urandom_range(0, 6), n);
    done += n;
    while (done < quota) begin
      r = $urandom_range(0, 99);
      if (r < 40) begin
        send_char(pick_code());
        pull_cell(($urandom_range(0, 4) == 0) ? $urandom_range(0, 6) : 48, n);
        done += n + 1;
      end else if (r < 48) begin
        send_beat(ACT_PULL, $urandom, $urandom, $urandom, $urandom);
        done++;
      end else if (r < 56) begin
        send_char(8'($urandom_range(1, SELECT_CODES - 1)));
        done++;
      end else if (r < 61) begin
        send_beat(ACT_START, $urandom, $urandom, $urandom, $urandom);
        done++;
      end else if (r < 67) begin
        send_beat(ACT_FIRST, $urandom, $urandom, $urandom, $urandom);
        done++;
      end else if (r < 72) begin
        send_char(8'd0);
      end else if (r < 77) begin
        send_beat(ACTION_W'($urandom_range(ACT_START + 1, (1 << ACTION_W) - 1)),
                  $urandom, $urandom, $urandom, $urandom);
      end else if (r < 84) begin
        send_beat(ACT_WRITE, $urandom, $urandom, $urandom, $urandom);
        done++;
      end else if (r < 88) begin
        drain_outputs();
      end else begin
        send_char(pick_code());
        done++;
      end
    end
  endtask

  initial begin
    logic [7:0]  wide_code;
    logic [15:0] b;
    int          n;
    sb = new();
    foreach (code_pool[i]) code_pool[i] = 8'($urandom_range(SELECT_CODES, 255));
    code_pool[0] = SELECT_CODES;
    code_pool[1] = 8'hFF;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    send_beat(ACT_FIRST, $urandom, 8'd32, 3'd0, $urandom);
    send_beat(ACT_FIRST, $urandom, 8'd200, 3'd1, $urandom);
    send_beat(ACT_START, $urandom, $urandom, $urandom, $urandom);
    send_char(8'd0);
    prepare_glyph(8'd65, 8'd3);
    send_char(8'd65);
    pull_cell(64, n);
    send_beat(ACT_PULL, $urandom, $urandom, $urandom, $urandom);
    prepare_glyph(8'hFF, 8'd4);
    send_char(8'hFF);
    pull_cell(5, n);
    prepare_glyph(SELECT_CODES, 8'd2);
    send_char(SELECT_CODES);
    pull_cell(64, n);
    send_char(8'd3);
    send_beat(ACT_FIRST, $urandom, 8'd250, 3'd2, $urandom);
    prepare_glyph(8'd10, 8'd2);
    send_char(8'd10);
    pull_cell(12, n);
    send_char(SELECT_CODES - 8'd1);
    prepare_glyph(8'd200, 8'd1);
    send_char(8'd200);
    pull_cell(12, n);
    send_char(8'd1);
    prepare_glyph(8'd100, 8'd0);
    send_char(8'd100);
    send_beat(ACT_PULL, $urandom, $urandom, $urandom, $urandom);
    for (int a = ACT_START + 1; a < (1 << ACTION_W); a++)
      send_beat(ACTION_W'(a), $urandom, $urandom, $urandom, $urandom);
    send_beat(ACT_START, $urandom, $urandom, $urandom, $urandom);
    drain_outputs();

    write_settings($urandom, $urandom, 5'd31, 6'd32, 3'd4);
    send_beat(ACT_START, $urandom, $urandom, $urandom, $urandom);
    wide_code = 8'd77;
    b = sb.base_for(wide_code);
    send_beat(ACT_WRITE, b, 8'hFF, $urandom, $urandom);
    prepare_glyph(wide_code, 8'hFF);
    repeat (240) send_char(wide_code);
    pull_cell(40, n);
    random_phase(60);

    write_settings(16'h0000, 16'hFFFF, 5'd0, 6'd1, 3'd1);
    random_phase(60);
    write_settings($urandom, $urandom, 5'd3, 6'd0, 3'd2);
    random_phase(50);
    write_settings($urandom, $urandom, 5'd1, 6'd63, 3'd7);
    random_phase(60);
    write_settings($urandom, $urandom, 5'd2, 6'd12, 3'd0);
    random_phase(50);
    write_settings(16'hFFFF, 16'h0000, $urandom, 6'd17, 3'd3);
    random_phase(60);
    repeat (3) begin
      write_settings($urandom, $urandom, $urandom, $urandom_range(1, MAX_ROWS_DEF),
                     $urandom_range(1, MAX_COLUMN_BYTES));
      random_phase(60);
    end
    drain_outputs();

    if (sb.failures == 0 && sb.awaited.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #1_000_000;
    $display("status: fail");
    $finish;
  end

endmodule
